### rtl/wma_pkg.sv
// ----------------------------------------------------------------------------
// Moving average package
// Shared widths and default window depth for the moving average block.
// ----------------------------------------------------------------------------
package wma_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_DEF = 64;

endpackage

### rtl/windowed_moving_average.sv
// ----------------------------------------------------------------------------
// Windowed moving average
// Mean of the last WINDOW unsigned Q8.8 samples, truncated toward zero.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_sample takes one sample per transfer.
// Result channel out_valid/out_ready/out_average gives one average per sample.
// Samples are kept in a WINDOW-deep ring memory with a running sum; the sum is
// divided by the fill count in a restoring divider that retires one quotient
// bit per cycle.
// Steps: the ring is read at the input transfer, the sum and ring are updated,
// the divider produces SUM_W quotient bits (clog2(WINDOW) + 16), and the
// output register is loaded once it is free.
// in_ready is high only while no sample is in work, so a new sample is not
// taken before the last result has been loaded into the output register.
// The output register holds a finished average until it is taken; the next
// sample may be accepted meanwhile, and its result waits in the divider until
// the output register frees. A stalled receiver therefore stalls the input
// after at most one further sample.
// Reset (rst_n low, synchronous) empties the window: sum, write position and
// fill count go to zero. The ring contents need no clearing, since an entry is
// only read back once the whole ring has been written.
// ----------------------------------------------------------------------------
module windowed_moving_average #(
  parameter int WINDOW = wma_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wma_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wma_pkg::SAMPLE_W-1:0] out_average
);

  localparam int SW     = wma_pkg::SAMPLE_W;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW) + SW;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [SW-1:0]     ring [WINDOW];
  logic [SW-1:0]     old_r;
  logic [SW-1:0]     sample_r, sample_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SW-1:0]     out_average_r, out_average_nxt;

  logic              in_xfer;
  logic              full;
  logic [SUM_W-1:0]  sum_upd;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    cnt_ext;
  logic              q_bit;
  logic              out_free;

  assign in_ready    = (state_r == S_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;
  assign out_free    = !out_valid_r || out_ready;

  assign full    = (cnt_r == CNT_FULL);
  assign sum_upd = sum_r - (full ? SUM_W'(old_r) : '0) + SUM_W'(sample_r);
  assign rem_sh  = {rem_r, div_r[SUM_W-1]};
  assign cnt_ext = {1'b0, cnt_r};
  assign q_bit   = (rem_sh >= cnt_ext);

  // ring: read on the input transfer, written during the update cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      old_r <= ring[pos_r];
    end
    if (state_r == S_UPDATE) begin
      ring[pos_r] <= sample_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    sample_nxt      = sample_r;
    sum_nxt         = sum_r;
    pos_nxt         = pos_r;
    cnt_nxt         = cnt_r;
    div_nxt         = div_r;
    rem_nxt         = rem_r;
    step_nxt        = step_r;
    out_valid_nxt   = out_valid_r;
    out_average_nxt = out_average_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          sample_nxt = in_sample;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        sum_nxt  = sum_upd;
        div_nxt  = sum_upd;
        rem_nxt  = '0;
        step_nxt = STEP_LAST;
        pos_nxt  = (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
        if (!full) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = q_bit ? CNT_W'(rem_sh - cnt_ext) : rem_sh[CNT_W-1:0];
        div_nxt = {div_r[SUM_W-2:0], q_bit};
        if (step_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = div_r[SW-1:0];
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r      <= sample_nxt;
    div_r         <= div_nxt;
    rem_r         <= rem_nxt;
    step_r        <= step_nxt;
    out_average_r <= out_average_nxt;
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed moving average testbench
// Streams Q8.8 samples through the block and checks every average against
// a cycle-free running-mean predictor. The stimulus covers extreme samples
// while the window fills, truncation of the mean, wraparound once the ring is
// full, full-scale sums, and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SAMPLE_W   = wma_pkg::SAMPLE_W;
  localparam int WINDOW     = wma_pkg::WINDOW_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN      = 40;
  localparam int MAX_REPORT = 10;

  typedef enum int {
    PAT_UNIFORM,
    PAT_FULL_SCALE,
    PAT_ZERO,
    PAT_SMALL,
    PAT_NEAR_MAX,
    PAT_ONE_HOT,
    PAT_EXTREMES
  } pattern_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] out_average;

  // window predictor state
  logic [SAMPLE_W-1:0] held_samples [WINDOW];
  int unsigned         window_sum  = 0;
  int unsigned         write_slot  = 0;
  int unsigned         held_count  = 0;
  int unsigned         peak_sum    = 0;

  logic [SAMPLE_W-1:0] expected_averages [$];
  logic [SAMPLE_W-1:0] wanted_average;

  bit idle_on          = 1'b0;
  int stall_left       = 0;
  int idle_cycles      = 0;
  int samples_sent     = 0;
  int averages_checked = 0;
  int mismatches       = 0;

  windowed_moving_average #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_average(out_average)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] window_mean(input logic [SAMPLE_W-1:0] s);
    if (held_count < WINDOW) begin
      held_count++;
    end else begin
      window_sum -= held_samples[write_slot];
    end
    window_sum += s;
    held_samples[write_slot] = s;
    write_slot = (write_slot == WINDOW - 1) ? 0 : write_slot + 1;
    if (window_sum > peak_sum) begin
      peak_sum = window_sum;
    end
    return SAMPLE_W'(window_sum / held_count);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input pattern_t pat);
    case (pat)
      PAT_FULL_SCALE: return '1;
      PAT_ZERO:       return '0;
      PAT_SMALL:      return SAMPLE_W'($urandom_range(0, 15));
      PAT_NEAR_MAX:   return SAMPLE_W'(16'hFFFF - $urandom_range(0, 255));
      PAT_ONE_HOT:    return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
      PAT_EXTREMES:   return $urandom_range(0, 1) ? '1 : '0;
      default:        return SAMPLE_W'($urandom);
    endcase
  endfunction

  // input transfers feed the predictor; output transfers are checked in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_averages.push_back(window_mean(in_sample));
      end
      if (out_valid && out_ready) begin
        if (expected_averages.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORT) begin
            $display("%0t: average %0d with no sample pending", $time, out_average);
          end
        end else begin
          wanted_average = expected_averages.pop_front();
          averages_checked++;
          if (out_average !== wanted_average) begin
            mismatches++;
            if (mismatches <= MAX_REPORT) begin
              $display("%0t: average mismatch, expected %0d got %0d",
                       $time, wanted_average, out_average);
            end
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // receiver stalls in random bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  // called just after a falling edge, returns just after the falling edge past its transfer
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!(in_valid && in_ready));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic test_fill_extremes();
    logic [SAMPLE_W-1:0] fill_seq [12];
    fill_seq = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h8000, 16'h7FFF,
                 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h0100, 16'hFFFE};
    idle_on = 1'b0;
    foreach (fill_seq[i]) begin
      send_sample(fill_seq[i]);
    end
  endtask

  // drives the running sum toward its full-scale value and past a wrap
  task automatic test_saturated_window();
    idle_on = 1'b1;
    repeat (WINDOW + 8) begin
      send_sample($urandom_range(0, 1) ? pick_sample(PAT_FULL_SCALE)
                                       : pick_sample(PAT_NEAR_MAX));
    end
  endtask

  task automatic test_random_stream(input int count);
    int       sent;
    int       run_len;
    pattern_t pat;
    sent = 0;
    while (sent < count) begin
      pat     = pattern_t'($urandom_range(PAT_UNIFORM, PAT_EXTREMES));
      run_len = $urandom_range(1, WINDOW + 32);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < run_len && sent < count; i++) begin
        send_sample(pick_sample(pat));
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) begin
      send_sample(pick_sample(PAT_UNIFORM));
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_fill_extremes();
    test_saturated_window();
    test_random_stream(850);
    test_back_to_back(170);

    in_valid <= 1'b0;
    while (expected_averages.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d samples, checked %0d averages over fill, wrap and idle phases",
             samples_sent, averages_checked);
    $display("Peak running sum %0d of %0d, %0d mismatches",
             peak_sum, WINDOW * 65535, mismatches);
    if (mismatches == 0 && expected_averages.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
